FILE: design/fqc_pkg.sv
// ----------------------------------------------------------------------------
// fqc_pkg
// Shared types and codes for the compacting FIFO queue: request and response
// transfer structs, request kinds, status codes and controller states.
// ----------------------------------------------------------------------------
package fqc_pkg;

  localparam int VALUE_W = 32;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQUEUE = 3'd0,
    KIND_DEQUEUE = 3'd1,
    KIND_PEEK    = 3'd2,
    KIND_EDIT    = 3'd3,
    KIND_REMOVE  = 3'd4,
    KIND_DEDUP   = 3'd5,
    KIND_EVENS   = 3'd6,
    KIND_CLEAR   = 3'd7
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_FIND,
    S_SHIFT,
    S_EVEN,
    S_DUP_OUTER,
    S_DUP_INNER
  } state_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [VALUE_W-1:0]  item_value;
    logic signed [VALUE_W-1:0]  new_value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  read_data;
    status_t                    status;
    logic [OCC_W-1:0]           occupancy;
  } rsp_t;

endpackage

FILE: design/fqc_ram.sv
// ----------------------------------------------------------------------------
// fqc_ram
// Entry store of the queue: one write port and one read port with the read
// data registered, so the data of a read appears in the cycle after its address.
// ----------------------------------------------------------------------------
module fqc_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [DATA_WIDTH-1:0]         rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/fifo_queue_with_compaction_core.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_compaction_core
// Bounded FIFO of signed words with search, edit, remove and in-place
// compaction requests, built around a single-port-read entry memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and its single
// response appears on rsp with done high for exactly one cycle, in the cycle
// after the request finishes; the receiver cannot stall it. Enqueue, clear and
// requests on an empty queue finish in the cycle of the transfer, so a new
// request can follow in the next cycle. Dequeue and peek read the head entry
// in S_HEAD. Edit and remove read one entry per cycle, from the head onward.
// Dropping even values reads every entry once. Dropping repeated values
// compares each entry against the survivors one read at a time. The pace of
// these scans is set by the one read port of the entry memory. Entries keep
// their order; the position of the head in the memory is internal and never
// visible.
module fifo_queue_with_compaction_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  fqc_pkg::req_t  req,
  output logic           busy,
  output logic           done,
  output fqc_pkg::rsp_t  rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = fqc_pkg::VALUE_W;
  localparam int OW = fqc_pkg::OCC_W;

  fqc_pkg::state_t state, state_next;
  fqc_pkg::kind_t  op, op_next;
  logic [AW-1:0]   head, head_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   idx, idx_next;
  logic [CW-1:0]   jdx, jdx_next;
  logic [CW-1:0]   wn, wn_next;
  logic [DATA_WIDTH-1:0] key, key_next;
  logic [DATA_WIDTH-1:0] repl, repl_next;
  logic [DATA_WIDTH-1:0] val, val_next;
  logic            done_next;
  fqc_pkg::rsp_t   rsp_next;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic [CW-1:0] idx_inc;
  logic [CW-1:0] jdx_inc;
  logic [CW-1:0] wn_inc;
  logic          idx_more;
  logic          jdx_more;
  logic [AW-1:0] head_inc;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(pos);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  assign idx_inc  = idx + CW'(1);
  assign jdx_inc  = jdx + CW'(1);
  assign wn_inc   = wn + CW'(1);
  assign idx_more = idx_inc < count;
  assign jdx_more = jdx_inc < wn;
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign busy     = (state != fqc_pkg::S_IDLE);

  fqc_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fqc_pkg::S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op   <= op_next;
    idx  <= idx_next;
    jdx  <= jdx_next;
    wn   <= wn_next;
    key  <= key_next;
    repl <= repl_next;
    val  <= val_next;
    rsp  <= rsp_next;
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    head_next  = head;
    count_next = count;
    idx_next   = idx;
    jdx_next   = jdx;
    wn_next    = wn;
    key_next   = key;
    repl_next  = repl;
    val_next   = val;
    we         = 1'b0;
    waddr      = head;
    wdata      = key;
    raddr      = head;
    done_next  = 1'b0;
    rsp_next.read_data = '0;
    rsp_next.status    = fqc_pkg::ST_OK;
    rsp_next.occupancy = OW'(count);

    unique case (state)
      fqc_pkg::S_IDLE: begin
        if (start) begin
          op_next   = req.kind;
          key_next  = DATA_WIDTH'(req.item_value);
          repl_next = DATA_WIDTH'(req.new_value);
          idx_next  = '0;
          jdx_next  = '0;
          wn_next   = '0;
          unique case (req.kind)
            fqc_pkg::KIND_ENQUEUE: begin
              done_next = 1'b1;
              if (count == CW'(DEPTH)) begin
                rsp_next.status = fqc_pkg::ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = slot(head, count);
                wdata      = DATA_WIDTH'(req.item_value);
                count_next = count + CW'(1);
                rsp_next.occupancy = OW'(count + CW'(1));
              end
            end
            fqc_pkg::KIND_DEQUEUE, fqc_pkg::KIND_PEEK,
            fqc_pkg::KIND_EDIT, fqc_pkg::KIND_REMOVE: begin
              if (count == '0) begin
                done_next       = 1'b1;
                rsp_next.status = fqc_pkg::ST_EMPTY;
              end else if (req.kind == fqc_pkg::KIND_DEQUEUE ||
                           req.kind == fqc_pkg::KIND_PEEK) begin
                state_next = fqc_pkg::S_HEAD;
              end else begin
                state_next = fqc_pkg::S_FIND;
              end
            end
            fqc_pkg::KIND_DEDUP, fqc_pkg::KIND_EVENS: begin
              if (count == '0) begin
                done_next = 1'b1;
              end else if (req.kind == fqc_pkg::KIND_DEDUP) begin
                state_next = fqc_pkg::S_DUP_OUTER;
              end else begin
                state_next = fqc_pkg::S_EVEN;
              end
            end
            fqc_pkg::KIND_CLEAR: begin
              done_next  = 1'b1;
              head_next  = '0;
              count_next = '0;
              rsp_next.occupancy = '0;
            end
          endcase
        end
      end

      fqc_pkg::S_HEAD: begin
        done_next          = 1'b1;
        state_next         = fqc_pkg::S_IDLE;
        rsp_next.read_data = VW'($signed(rdata));
        if (op == fqc_pkg::KIND_DEQUEUE) begin
          head_next  = head_inc;
          count_next = count - CW'(1);
          rsp_next.occupancy = OW'(count - CW'(1));
        end
      end

      fqc_pkg::S_FIND: begin
        if (rdata == key) begin
          if (op == fqc_pkg::KIND_EDIT) begin
            we         = 1'b1;
            waddr      = slot(head, idx);
            wdata      = repl;
            done_next  = 1'b1;
            state_next = fqc_pkg::S_IDLE;
          end else if (idx_more) begin
            raddr      = slot(head, idx_inc);
            idx_next   = idx_inc;
            state_next = fqc_pkg::S_SHIFT;
          end else begin
            count_next = count - CW'(1);
            rsp_next.occupancy = OW'(count - CW'(1));
            done_next  = 1'b1;
            state_next = fqc_pkg::S_IDLE;
          end
        end else if (idx_more) begin
          raddr    = slot(head, idx_inc);
          idx_next = idx_inc;
        end else begin
          rsp_next.status = fqc_pkg::ST_NOT_FOUND;
          done_next       = 1'b1;
          state_next      = fqc_pkg::S_IDLE;
        end
      end

      fqc_pkg::S_SHIFT: begin
        we    = 1'b1;
        waddr = slot(head, idx - CW'(1));
        wdata = rdata;
        if (idx_more) begin
          raddr    = slot(head, idx_inc);
          idx_next = idx_inc;
        end else begin
          count_next = count - CW'(1);
          rsp_next.occupancy = OW'(count - CW'(1));
          done_next  = 1'b1;
          state_next = fqc_pkg::S_IDLE;
        end
      end

      fqc_pkg::S_EVEN: begin
        if (rdata[0]) begin
          we      = 1'b1;
          waddr   = slot(head, wn);
          wdata   = rdata;
          wn_next = wn_inc;
        end
        if (idx_more) begin
          raddr    = slot(head, idx_inc);
          idx_next = idx_inc;
        end else begin
          count_next = wn_next;
          rsp_next.occupancy = OW'(wn_next);
          done_next  = 1'b1;
          state_next = fqc_pkg::S_IDLE;
        end
      end

      fqc_pkg::S_DUP_OUTER: begin
        val_next = rdata;
        if (wn == '0) begin
          we      = 1'b1;
          waddr   = slot(head, wn);
          wdata   = rdata;
          wn_next = wn_inc;
          if (idx_more) begin
            raddr    = slot(head, idx_inc);
            idx_next = idx_inc;
          end else begin
            count_next = wn_inc;
            rsp_next.occupancy = OW'(wn_inc);
            done_next  = 1'b1;
            state_next = fqc_pkg::S_IDLE;
          end
        end else begin
          raddr      = head;
          jdx_next   = '0;
          state_next = fqc_pkg::S_DUP_INNER;
        end
      end

      fqc_pkg::S_DUP_INNER: begin
        if (rdata != val && jdx_more) begin
          raddr    = slot(head, jdx_inc);
          jdx_next = jdx_inc;
        end else begin
          if (rdata != val) begin
            we      = 1'b1;
            waddr   = slot(head, wn);
            wdata   = val;
            wn_next = wn_inc;
          end
          if (idx_more) begin
            raddr      = slot(head, idx_inc);
            idx_next   = idx_inc;
            state_next = fqc_pkg::S_DUP_OUTER;
          end else begin
            count_next = wn_next;
            rsp_next.occupancy = OW'(wn_next);
            done_next  = 1'b1;
            state_next = fqc_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_next = fqc_pkg::S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds the queue depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= AW'(DEPTH - 1))
    else $error("head index outside the entry store");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == fqc_pkg::S_FIND || state == fqc_pkg::S_SHIFT ||
     state == fqc_pkg::S_EVEN || state == fqc_pkg::S_DUP_OUTER ||
     state == fqc_pkg::S_DUP_INNER) |-> (idx < count))
    else $error("scan position beyond the occupied entries");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (state == fqc_pkg::S_EVEN || state == fqc_pkg::S_DUP_OUTER ||
     state == fqc_pkg::S_DUP_INNER) |-> (wn <= idx))
    else $error("compaction write position passed the read position");

  a_inner_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == fqc_pkg::S_DUP_INNER) |-> (jdx < wn))
    else $error("duplicate search beyond the kept entries");

  a_done_follows_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != fqc_pkg::S_IDLE || start))
    else $error("response without a request in progress");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the compacting FIFO queue. A scripted sequence
// covers the empty and full queue, the extreme values, every request kind and
// the order kept by compaction, then random phases that lean toward filling,
// draining or a mix. Every accepted request is run through an in-bench model
// of the queue and each response is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUEUE_DEPTH     = 16;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 200;
  localparam int RANDOM_SEGMENTS = 13;
  localparam int SEGMENT_LEN     = 50;
  localparam int SCRIPT_LEN      = 25;

  typedef enum int {
    LEAN_FILL,
    LEAN_DRAIN,
    LEAN_MIXED
  } lean_t;

  typedef struct {
    fqc_pkg::kind_t                     kind;
    logic signed [fqc_pkg::VALUE_W-1:0] item_value;
    logic signed [fqc_pkg::VALUE_W-1:0] new_value;
    int                                 reps;
    bit                                 fixed;
    fqc_pkg::rsp_t                      want;
  } step_t;

  logic          clk;
  logic          rst;
  logic          start;
  fqc_pkg::req_t req;
  logic          busy;
  logic          done;
  fqc_pkg::rsp_t rsp;

  bit            pin_valid;
  fqc_pkg::rsp_t pin_rsp;

  logic signed [fqc_pkg::VALUE_W-1:0] queue_image[$];
  fqc_pkg::rsp_t                      pending_rsp[$];
  int                                 errors;
  int                                 idle_cycles;

  step_t script [SCRIPT_LEN] = '{
    '{fqc_pkg::KIND_DEQUEUE, 32'sd0, 32'sd0, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_EMPTY, 5'd0}},
    '{fqc_pkg::KIND_PEEK, 32'sd0, 32'sd0, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_EMPTY, 5'd0}},
    '{fqc_pkg::KIND_EDIT, 32'sd0, 32'sd0, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_EMPTY, 5'd0}},
    '{fqc_pkg::KIND_REMOVE, 32'sd0, 32'sd0, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_EMPTY, 5'd0}},
    '{fqc_pkg::KIND_DEDUP, 32'sd0, 32'sd0, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_OK, 5'd0}},
    '{fqc_pkg::KIND_EVENS, 32'sd0, 32'sd0, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_OK, 5'd0}},
    '{fqc_pkg::KIND_ENQUEUE, 32'sh80000000, 32'sd0, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_OK, 5'd1}},
    '{fqc_pkg::KIND_ENQUEUE, 32'sh7FFFFFFF, 32'sd0, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_OK, 5'd2}},
    '{fqc_pkg::KIND_ENQUEUE, -32'sd1, 32'sd0, 14, 1'b0, '0},
    '{fqc_pkg::KIND_ENQUEUE, 32'sd3, 32'sd0, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_FULL, 5'd16}},
    '{fqc_pkg::KIND_PEEK, 32'sd0, 32'sd0, 1, 1'b1,
      '{32'sh80000000, fqc_pkg::ST_OK, 5'd16}},
    '{fqc_pkg::KIND_DEQUEUE, 32'sd0, 32'sd0, 1, 1'b1,
      '{32'sh80000000, fqc_pkg::ST_OK, 5'd15}},
    '{fqc_pkg::KIND_ENQUEUE, -32'sd2, 32'sd0, 1, 1'b0, '0},
    '{fqc_pkg::KIND_EDIT, 32'sd7, 32'sh7FFFFFFF, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_NOT_FOUND, 5'd16}},
    '{fqc_pkg::KIND_EDIT, -32'sd2, 32'sh80000000, 1, 1'b0, '0},
    '{fqc_pkg::KIND_REMOVE, -32'sd1, 32'sd0, 1, 1'b0, '0},
    '{fqc_pkg::KIND_DEDUP, 32'sd0, 32'sd0, 1, 1'b0, '0},
    '{fqc_pkg::KIND_ENQUEUE, 32'sd6, 32'sd0, 1, 1'b0, '0},
    '{fqc_pkg::KIND_ENQUEUE, -32'sd5, 32'sd0, 1, 1'b0, '0},
    '{fqc_pkg::KIND_EVENS, 32'sd0, 32'sd0, 1, 1'b0, '0},
    '{fqc_pkg::KIND_REMOVE, -32'sd5, 32'sd0, 1, 1'b0, '0},
    '{fqc_pkg::KIND_DEQUEUE, 32'sd0, 32'sd0, 1, 1'b1,
      '{32'sh7FFFFFFF, fqc_pkg::ST_OK, 5'd1}},
    '{fqc_pkg::KIND_PEEK, 32'sd0, 32'sd0, 1, 1'b1,
      '{-32'sd1, fqc_pkg::ST_OK, 5'd1}},
    '{fqc_pkg::KIND_CLEAR, 32'sd0, 32'sd0, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_OK, 5'd0}},
    '{fqc_pkg::KIND_PEEK, 32'sd0, 32'sd0, 1, 1'b1,
      '{32'sd0, fqc_pkg::ST_EMPTY, 5'd0}}
  };

  fifo_queue_with_compaction_core u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic apply_request(input fqc_pkg::req_t r, output fqc_pkg::rsp_t res);
    int                                 found;
    bit                                 dup;
    logic signed [fqc_pkg::VALUE_W-1:0] kept[$];
    res.read_data = '0;
    res.status    = fqc_pkg::ST_OK;
    case (r.kind)
      fqc_pkg::KIND_ENQUEUE: begin
        if (queue_image.size() >= QUEUE_DEPTH) res.status = fqc_pkg::ST_FULL;
        else queue_image.push_back(r.item_value);
      end
      fqc_pkg::KIND_DEQUEUE, fqc_pkg::KIND_PEEK: begin
        if (queue_image.size() == 0) begin
          res.status = fqc_pkg::ST_EMPTY;
        end else begin
          res.read_data = queue_image[0];
          if (r.kind == fqc_pkg::KIND_DEQUEUE) void'(queue_image.pop_front());
        end
      end
      fqc_pkg::KIND_EDIT, fqc_pkg::KIND_REMOVE: begin
        if (queue_image.size() == 0) begin
          res.status = fqc_pkg::ST_EMPTY;
        end else begin
          found = -1;
          foreach (queue_image[i])
            if (found < 0 && queue_image[i] == r.item_value) found = i;
          if (found < 0) res.status = fqc_pkg::ST_NOT_FOUND;
          else if (r.kind == fqc_pkg::KIND_EDIT) queue_image[found] = r.new_value;
          else queue_image.delete(found);
        end
      end
      fqc_pkg::KIND_DEDUP: begin
        foreach (queue_image[i]) begin
          dup = 1'b0;
          foreach (kept[j])
            if (kept[j] == queue_image[i]) dup = 1'b1;
          if (!dup) kept.push_back(queue_image[i]);
        end
        queue_image = kept;
      end
      fqc_pkg::KIND_EVENS: begin
        foreach (queue_image[i])
          if (queue_image[i][0]) kept.push_back(queue_image[i]);
        queue_image = kept;
      end
      default: queue_image.delete();
    endcase
    res.occupancy = (fqc_pkg::OCC_W)'(queue_image.size());
  endtask

  always @(posedge clk) begin : monitor
    fqc_pkg::rsp_t want;
    fqc_pkg::rsp_t got;
    if (!rst && start === 1'b1 && busy === 1'b0) begin
      apply_request(req, want);
      if (pin_valid) want = pin_rsp;
      pending_rsp.push_back(want);
    end
    if (!rst && done === 1'b1) begin
      got = rsp;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: response with none pending: read_data %0d status %0d occupancy %0d",
                 $time, got.read_data, got.status, got.occupancy);
      end else begin
        want = pending_rsp.pop_front();
        if (got.read_data !== want.read_data) begin
          errors++;
          $display("%0t: read_data expected %0d got %0d", $time, want.read_data,
                   got.read_data);
        end
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        end
        if (got.occupancy !== want.occupancy) begin
          errors++;
          $display("%0t: occupancy expected %0d got %0d", $time, want.occupancy,
                   got.occupancy);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || done === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  task automatic send_request(input fqc_pkg::req_t r, input bit fixed,
                              input fqc_pkg::rsp_t want, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    pin_valid <= fixed;
    pin_rsp   <= want;
    start     <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending_rsp.size() != 0);
  endtask

  function automatic fqc_pkg::kind_t pick_kind(input lean_t lean);
    int roll;
    int enq_share;
    roll      = $urandom_range(0, 99);
    enq_share = (lean == LEAN_FILL) ? 80 : (lean == LEAN_DRAIN) ? 15 : 35;
    if (roll < enq_share) return fqc_pkg::KIND_ENQUEUE;
    if (roll >= 97) return fqc_pkg::KIND_CLEAR;
    case (roll % 6)
      0:       return fqc_pkg::KIND_DEQUEUE;
      1:       return fqc_pkg::KIND_PEEK;
      2:       return fqc_pkg::KIND_EDIT;
      3:       return fqc_pkg::KIND_REMOVE;
      4:       return fqc_pkg::KIND_DEDUP;
      default: return fqc_pkg::KIND_EVENS;
    endcase
  endfunction

  // Most values come from a small set so that searches and dedup find matches.
  function automatic logic signed [fqc_pkg::VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 9) >= 6) return $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'sd0;
      1:       return 32'sd1;
      2:       return -32'sd1;
      3:       return 32'sd2;
      4:       return -32'sd2;
      5:       return 32'sd3;
      6:       return 32'sh7FFFFFFF;
      default: return 32'sh80000000;
    endcase
  endfunction

  initial begin : stimulus
    fqc_pkg::req_t r;
    lean_t         lean;
    bit            no_gaps;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    pin_valid = 1'b0;
    pin_rsp   = '0;
    errors    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      for (int n = 0; n < script[i].reps; n++) begin
        r.kind       = script[i].kind;
        r.item_value = script[i].item_value;
        r.new_value  = script[i].new_value;
        send_request(r, script[i].fixed, script[i].want, $urandom_range(0, 15));
      end
    end
    drain_results();

    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      lean    = lean_t'($urandom_range(0, 2));
      no_gaps = ($urandom_range(0, 2) == 0);
      if (seg > 0 && $urandom_range(0, 3) == 0) drain_results();
      for (int k = 0; k < SEGMENT_LEN; k++) begin
        r.kind       = pick_kind(lean);
        r.item_value = pick_value();
        r.new_value  = pick_value();
        send_request(r, 1'b0, '0, no_gaps ? 0 : $urandom_range(0, 15));
      end
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
